// ----- src/wrmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmv_pkg: shared types and constants
// Field widths, item codes, controller states and the command and status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package wrmv_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int COUNT_BITS    = 24;
   localparam int FRAC_BITS     = 16;
   localparam int MEAN_BITS     = SAMPLE_BITS + FRAC_BITS;
   localparam int DEV_BITS      = SAMPLE_BITS + 1;
   localparam int PROD_BITS     = 2 * DEV_BITS;
   localparam int SUM_BITS      = 32;
   localparam int TIME_BITS     = 32;
   localparam int CHAN_BITS     = 4;
   localparam int DIV_STEPS     = MEAN_BITS;
   localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_START  = 2'd1,
      MODE_STOP   = 2'd2,
      MODE_ACK    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MEAN,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic mean_upd;
      logic sum_upd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic first;
      logic rsp_busy;
   } dp_sts_type;

endpackage

// ----- src/wrmv_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmv_intf: request and response channels
// Valid/ready channels carrying the input item and the window result item.
// ----------------------------------------------------------------------------
interface wrmv_req_if import wrmv_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             mode;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TIME_BITS-1:0]   time_us;
   logic [TIME_BITS-1:0]   time_ms;

   modport source (output valid, mode, sample, time_us, time_ms, input ready);
   modport sink   (input valid, mode, sample, time_us, time_ms, output ready);
endinterface

interface wrmv_rsp_if import wrmv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] sample_total;
   logic [MEAN_BITS-1:0]  mean_value;
   logic [SUM_BITS-1:0]   square_sum;
   logic [TIME_BITS-1:0]  interval_us;
   logic [TIME_BITS-1:0]  stamp_ms;
   logic [CHAN_BITS-1:0]  channel_out;
   logic                  overrun;

   modport source (output valid, sample_total, mean_value, square_sum, interval_us,
                   stamp_ms, channel_out, overrun, input ready);
   modport sink   (input valid, sample_total, mean_value, square_sum, interval_us,
                   stamp_ms, channel_out, overrun, output ready);
endinterface

// ----- src/wrmv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmv_ctrl: sequencing controller
// Accepts items, steps the serial divider and orders the mean and sum updates.
// ----------------------------------------------------------------------------
module wrmv_ctrl import wrmv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_mode,
   input  dp_sts_type   sts,
   output logic         req_ready,
   output ctrl_cmd_type cmd
);

   state_type                state_ff, state_in;
   logic [STEP_CNT_BITS-1:0] step_cnt_ff, step_cnt_in;
   logic                     accept;
   logic                     last_step;

   assign last_step = (step_cnt_ff == STEP_CNT_BITS'(DIV_STEPS - 1));
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in    = state_ff;
      step_cnt_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_SAMPLE) && !sts.first) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            step_cnt_in = step_cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            // hold a stop while the result register is still full
            req_ready  = (req_mode != MODE_STOP) || !sts.rsp_busy;
            cmd.accept = req_valid && ((req_mode != MODE_STOP) || !sts.rsp_busy);
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_MEAN: begin
            cmd.mean_upd = 1'b1;
         end
         ST_SUM: begin
            cmd.sum_upd = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

endmodule

// ----- src/wrmv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmv_datapath: accumulators, serial divider and result register
// Holds count, mean and sum, runs a restoring divider one bit per cycle and
// captures the window result on stop.
// ----------------------------------------------------------------------------
module wrmv_datapath import wrmv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_sts_type             sts,
   input  logic [1:0]             req_mode,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic [TIME_BITS-1:0]   req_time_us,
   input  logic [TIME_BITS-1:0]   req_time_ms,
   input  logic                   csr_wr_en,
   input  logic [CHAN_BITS-1:0]   csr_wr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [COUNT_BITS-1:0]  rsp_sample_total,
   output logic [MEAN_BITS-1:0]   rsp_mean_value,
   output logic [SUM_BITS-1:0]    rsp_square_sum,
   output logic [TIME_BITS-1:0]   rsp_interval_us,
   output logic [TIME_BITS-1:0]   rsp_stamp_ms,
   output logic [CHAN_BITS-1:0]   rsp_channel_out,
   output logic                   rsp_overrun
);

   // architectural state
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [MEAN_BITS-1:0]   mean_ff, mean_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [TIME_BITS-1:0]   last_us_ff, last_us_in;
   logic                   ack_pend_ff, ack_pend_in;
   logic                   overrun_ff, overrun_in;
   logic                   stop_seen_ff, stop_seen_in;
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [SAMPLE_BITS-1:0]    x_ff, x_in;
   logic [COUNT_BITS-1:0]     divisor_ff, divisor_in;
   logic [COUNT_BITS-1:0]     rem_ff, rem_in;
   logic [MEAN_BITS-1:0]      quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   logic signed [DEV_BITS-1:0] dold_ff, dold_in;

   // result register
   logic [COUNT_BITS-1:0]  out_total_ff, out_total_in;
   logic [MEAN_BITS-1:0]   out_mean_ff, out_mean_in;
   logic [SUM_BITS-1:0]    out_sum_ff, out_sum_in;
   logic [TIME_BITS-1:0]   out_intv_ff, out_intv_in;
   logic [TIME_BITS-1:0]   out_ms_ff, out_ms_in;
   logic [CHAN_BITS-1:0]   out_chan_ff, out_chan_in;
   logic                   out_ovr_ff, out_ovr_in;

   logic [COUNT_BITS-1:0]      n_val;
   logic [MEAN_BITS:0]         diff;
   logic [MEAN_BITS-1:0]       diff_abs;
   logic [COUNT_BITS:0]        trial;
   logic                       fits;
   logic signed [DEV_BITS-1:0] dnew;
   logic signed [PROD_BITS-1:0] prod;

   assign n_val    = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign diff     = {1'b0, req_sample, {FRAC_BITS{1'b0}}} - {1'b0, mean_ff};
   assign diff_abs = diff[MEAN_BITS] ? MEAN_BITS'(-diff) : diff[MEAN_BITS-1:0];
   assign trial    = {rem_ff, quo_ff[MEAN_BITS-1]};
   assign fits     = (trial >= {1'b0, divisor_ff});
   assign dnew     = {1'b0, x_ff} - {1'b0, mean_ff[MEAN_BITS-1:FRAC_BITS]};
   assign prod     = dold_ff * dnew;

   assign sts.first    = (count_ff == '0);
   assign sts.rsp_busy = rsp_valid_ff;

   always_comb begin
      count_in     = count_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      last_us_in   = last_us_ff;
      ack_pend_in  = ack_pend_ff;
      overrun_in   = overrun_ff;
      stop_seen_in = stop_seen_ff;
      chan_in      = csr_wr_en ? csr_wr_data : chan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      x_in         = x_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      dold_in      = dold_ff;
      out_total_in = out_total_ff;
      out_mean_in  = out_mean_ff;
      out_sum_in   = out_sum_ff;
      out_intv_in  = out_intv_ff;
      out_ms_in    = out_ms_ff;
      out_chan_in  = out_chan_ff;
      out_ovr_in   = out_ovr_ff;

      if (cmd.accept) begin
         case (mode_type'(req_mode))
            MODE_SAMPLE: begin
               count_in = n_val;
               x_in     = req_sample;
               if (sts.first) begin
                  mean_in = {req_sample, {FRAC_BITS{1'b0}}};
                  sum_in  = '0;
               end else begin
                  rem_in     = '0;
                  quo_in     = diff_abs;
                  divisor_in = n_val;
                  neg_in     = diff[MEAN_BITS];
               end
            end
            MODE_START: begin
               count_in = '0;
               mean_in  = '0;
               sum_in   = '0;
            end
            MODE_STOP: begin
               overrun_in   = overrun_ff || ack_pend_ff;
               last_us_in   = req_time_us;
               stop_seen_in = 1'b1;
               ack_pend_in  = 1'b1;
               rsp_valid_in = 1'b1;
               out_total_in = count_ff;
               out_mean_in  = mean_ff;
               out_sum_in   = sum_ff;
               out_intv_in  = stop_seen_ff ? req_time_us - last_us_ff : '0;
               out_ms_in    = req_time_ms;
               out_chan_in  = chan_ff;
               out_ovr_in   = overrun_ff || ack_pend_ff;
            end
            MODE_ACK: begin
               ack_pend_in = 1'b0;
            end
            default: begin
               ack_pend_in = ack_pend_ff;
            end
         endcase
      end

      // restoring division: one quotient bit per cycle
      if (cmd.div_step) begin
         rem_in = fits ? COUNT_BITS'(trial - {1'b0, divisor_ff}) : COUNT_BITS'(trial);
         quo_in = {quo_ff[MEAN_BITS-2:0], fits};
      end

      // quotient truncated toward zero, sign put back here
      if (cmd.mean_upd) begin
         dold_in = {1'b0, x_ff} - {1'b0, mean_ff[MEAN_BITS-1:FRAC_BITS]};
         mean_in = neg_ff ? mean_ff - quo_ff : mean_ff + quo_ff;
      end

      if (cmd.sum_upd) begin
         sum_in = sum_ff + SUM_BITS'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         last_us_ff   <= '0;
         ack_pend_ff  <= 1'b0;
         overrun_ff   <= 1'b0;
         stop_seen_ff <= 1'b0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         last_us_ff   <= last_us_in;
         ack_pend_ff  <= ack_pend_in;
         overrun_ff   <= overrun_in;
         stop_seen_ff <= stop_seen_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      dold_ff      <= dold_in;
      out_total_ff <= out_total_in;
      out_mean_ff  <= out_mean_in;
      out_sum_ff   <= out_sum_in;
      out_intv_ff  <= out_intv_in;
      out_ms_ff    <= out_ms_in;
      out_chan_ff  <= out_chan_in;
      out_ovr_ff   <= out_ovr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_total = out_total_ff;
   assign rsp_mean_value   = out_mean_ff;
   assign rsp_square_sum   = out_sum_ff;
   assign rsp_interval_us  = out_intv_ff;
   assign rsp_stamp_ms     = out_ms_ff;
   assign rsp_channel_out  = out_chan_ff;
   assign rsp_overrun      = out_ovr_ff;

endmodule

// ----- src/windowed_running_mean_variance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_running_mean_variance: windowed running mean and variance
// Counts samples, keeps a running mean in unsigned Q10.16 and a wrapping
// sum of deviation products, and reports one result per measurement window.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              carries
//  -------  ---------  ---------------------  -------------------------------
//  req_ch   in         valid/ready            mode, sample, time_us, time_ms
//  rsp_ch   out        valid/ready            window result item
//  csr      in         csr_wr_en, no ready    input_channel (4 bits)
//
// A sample item is accepted, then runs the restoring divider (one quotient bit
// a cycle over the Q10.16 mean width), the mean update and the sum update; no
// new item is taken before that. The first sample of a window and every other
// item finish on acceptance. A stop is held off while the result register is
// still full; others flow on. Synchronous reset clears the architectural state.
//
module windowed_running_mean_variance import wrmv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   wrmv_req_if.sink             req_ch,
   wrmv_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CHAN_BITS-1:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;
   logic         req_ready;

   // sequence the work for each item
   wrmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // accumulators, divider and the result register
   wrmv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_ch.mode),
      .req_sample       (req_ch.sample),
      .req_time_us      (req_ch.time_us),
      .req_time_ms      (req_ch.time_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_sample_total (rsp_ch.sample_total),
      .rsp_mean_value   (rsp_ch.mean_value),
      .rsp_square_sum   (rsp_ch.square_sum),
      .rsp_interval_us  (rsp_ch.interval_us),
      .rsp_stamp_ms     (rsp_ch.stamp_ms),
      .rsp_channel_out  (rsp_ch.channel_out),
      .rsp_overrun      (rsp_ch.overrun)
   );

   // a stop never lands on a result that is still waiting
   a_stop_free : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.mode == MODE_STOP)) |-> !rsp_ch.valid)
      else $error("stop accepted while result pending");

   // a stop produces a result in the next cycle
   a_stop_emit : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.mode == MODE_STOP)) |=> rsp_ch.valid)
      else $error("stop without result");

   // after a sample the window count is never zero
   a_count_up : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.mode == MODE_SAMPLE)) |=> !sts.first)
      else $error("sample did not advance count");

   // a sample that divides closes the input once it is accepted
   a_div_busy : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.mode == MODE_SAMPLE) && !sts.first)
      |=> !req_ch.ready)
      else $error("item accepted during division");

endmodule
